>>> rtl/pbp_pkg.sv
// Shared types and constants for the perceptron branch predictor.
`default_nettype none
package pbp_pkg;
	localparam int SUM_W = 14;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HIST_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd2;

	localparam logic signed [SUM_W-1:0] SUM_MAX = 14'sd8191;
	localparam logic signed [SUM_W-1:0] SUM_MIN = -14'sd8192;

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE = 5'b00010,
		S_ROW = 5'b00100,
		S_SUM = 5'b01000,
		S_OUT = 5'b10000
	} state_t;
endpackage
`default_nettype wire

>>> rtl/perceptron_branch_predictor.sv
// Top level of the perceptron branch predictor: weight memory, history and sequencer.
// After reset the block clears all 2**MAX_INDEX_BITS rows of its weight memory (1024 by
// default), one row a cycle, with busy high. A predict transaction passes through the
// synchronous row read and then the two-level adder tree before the result strobe; a
// train transaction passes through the row read and then the read-modify-write of the
// row. The result_valid pulse lasts one cycle and cannot be stalled; a new start is
// taken in that same cycle.
`default_nettype none
module perceptron_branch_predictor import pbp_pkg::*; #(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_HISTORY = 32,
	parameter int WEIGHT_BITS = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic mode,
	input wire logic [31:0] pc,
	input wire logic outcome,
	output logic result_valid,
	output logic predict_taken,
	output logic signed [SUM_W-1:0] perceptron_sum,
	output logic weights_updated,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CFG_DATA_W-1:0] cfg_data
);
	localparam int ROWS = 1 << MAX_INDEX_BITS;
	localparam int ROW_LEN = MAX_HISTORY + 1;
	localparam int NGRP = (ROW_LEN + 7) / 8;
	localparam int PW = WEIGHT_BITS + 4;
	localparam int TW = WEIGHT_BITS + 7;
	localparam int HXW = (MAX_HISTORY > MAX_INDEX_BITS) ? MAX_HISTORY : MAX_INDEX_BITS;
	localparam logic [4:0] IB_MAX = 5'(MAX_INDEX_BITS);
	localparam logic [5:0] HL_MAX = 6'(MAX_HISTORY);

	typedef logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_t;

	state_t state_q;
	logic [MAX_INDEX_BITS-1:0] clr_q, idx_q, idx_c;
	logic [3:0] ibits_q;
	logic [5:0] hlen_q, hl;
	logic [12:0] thr_q;
	logic [MAX_HISTORY-1:0] hist_q;
	logic signed [SUM_W-1:0] saved_q;
	logic mode_q, outcome_q;
	row_t mem [ROWS];
	row_t row_s1, row_new;
	logic [NGRP-1:0][PW-1:0] part_s2;
	logic [ROW_LEN-1:0] act, xs;
	logic [HXW-1:0] hx;
	logic [4:0] ib;
	logic signed [TW-1:0] total;
	logic signed [SUM_W-1:0] sum_sat;
	logic [SUM_W-1:0] mag;
	logic do_upd, accept, mem_we;
	logic [MAX_INDEX_BITS-1:0] mem_wa;
	row_t mem_wd;

	assign busy = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign cfg_ready = 1'b1;

	assign hx = HXW'(hist_q);
	assign ib = ({1'b0, ibits_q} > IB_MAX) ? IB_MAX : {1'b0, ibits_q};
	assign hl = (hlen_q > HL_MAX) ? HL_MAX : hlen_q;

	always_comb begin
		for (int i = 0; i < MAX_INDEX_BITS; i++) begin
			idx_c[i] = (pc[i] ^ hx[i]) && (5'(i) < ib);
		end
		for (int k = 0; k < ROW_LEN; k++) begin
			act[k] = (k == 0) || (7'(k - 1) < {1'b0, hl});
			xs[k] = (k == 0) ? 1'b1 : hist_q[(k == 0) ? 0 : k - 1];
		end
	end

	pbp_row_update #(
		.WEIGHT_BITS(WEIGHT_BITS),
		.ROW_LEN(ROW_LEN)
	) u_upd (
		.row_in(row_s1),
		.lane_act(act),
		.lane_x(xs),
		.outcome(outcome_q),
		.row_out(row_new)
	);

	assign mag = saved_q[SUM_W-1] ? SUM_W'(-saved_q) : SUM_W'(saved_q);
	assign do_upd = (saved_q[SUM_W-1] == outcome_q) || ({1'b0, thr_q} >= mag);

	always_comb begin
		total = '0;
		for (int g = 0; g < NGRP; g++) begin
			total = total + TW'($signed(part_s2[g]));
		end
		if (total > TW'(SUM_MAX)) sum_sat = SUM_MAX;
		else if (total < TW'(SUM_MIN)) sum_sat = SUM_MIN;
		else sum_sat = SUM_W'(total);
	end

	assign mem_we = (state_q == S_CLEAR) || (state_q == S_ROW && mode_q && do_upd);
	assign mem_wa = (state_q == S_CLEAR) ? clr_q : idx_q;
	assign mem_wd = (state_q == S_CLEAR) ? row_t'(0) : row_new;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (accept) row_s1 <= mem[idx_c];
	end

	always_ff @(posedge clk) begin
		logic signed [PW-1:0] acc;
		for (int g = 0; g < NGRP; g++) begin
			acc = '0;
			for (int j = 0; j < 8; j++) begin
				if (g * 8 + j < ROW_LEN) begin
					if (act[g*8+j]) begin
						if (xs[g*8+j]) acc = acc + PW'($signed(row_s1[g*8+j]));
						else acc = acc - PW'($signed(row_s1[g*8+j]));
					end
				end
			end
			part_s2[g] <= acc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			idx_q <= '0;
			mode_q <= 1'b0;
			outcome_q <= 1'b0;
			ibits_q <= 4'd10;
			hlen_q <= 6'd32;
			thr_q <= 13'd75;
			hist_q <= '0;
			saved_q <= '0;
			result_valid <= 1'b0;
			predict_taken <= 1'b0;
			perceptron_sum <= '0;
			weights_updated <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_INDEX_BITS: ibits_q <= cfg_data[3:0];
					CFG_HIST_LEN: hlen_q <= cfg_data[5:0];
					CFG_THRESHOLD: thr_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						idx_q <= idx_c;
						mode_q <= mode;
						outcome_q <= outcome;
						state_q <= S_ROW;
					end
				end
				S_ROW: begin
					if (mode_q) begin
						for (int i = 0; i < MAX_HISTORY; i++) begin
							hist_q[i] <= (6'(i) < hl) &&
								((i == 0) ? outcome_q : hist_q[(i == 0) ? 0 : i - 1]);
						end
						result_valid <= 1'b1;
						predict_taken <= !saved_q[SUM_W-1];
						perceptron_sum <= saved_q;
						weights_updated <= do_upd;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					saved_q <= sum_sat;
					result_valid <= 1'b1;
					predict_taken <= !sum_sat[SUM_W-1];
					perceptron_sum <= sum_sat;
					weights_updated <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(state_q == S_SUM || (state_q == S_ROW && mode_q)))
		else $error("result without a finished transaction");
	a_clear_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy && !result_valid)
		else $error("clear pass not busy");
	a_accept_row: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> state_q == S_ROW)
		else $error("accepted transaction did not read its row");
	a_train_write: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && state_q != S_CLEAR |-> mode_q && state_q == S_ROW)
		else $error("row write outside a train transaction");
endmodule
`default_nettype wire

>>> rtl/pbp_row_update.sv
// Per-weight saturating training update of one perceptron row.
`default_nettype none
module pbp_row_update import pbp_pkg::*; #(
	parameter int WEIGHT_BITS = 8,
	parameter int ROW_LEN = 33
) (
	input wire logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_in,
	input wire logic [ROW_LEN-1:0] lane_act,
	input wire logic [ROW_LEN-1:0] lane_x,
	input wire logic outcome,
	output logic [ROW_LEN-1:0][WEIGHT_BITS-1:0] row_out
);
	localparam logic signed [WEIGHT_BITS-1:0] W_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};
	localparam logic signed [WEIGHT_BITS-1:0] W_MIN = {1'b1, {(WEIGHT_BITS-1){1'b0}}};

	always_comb begin
		logic signed [WEIGHT_BITS-1:0] w;
		for (int k = 0; k < ROW_LEN; k++) begin
			w = row_in[k];
			row_out[k] = row_in[k];
			if (lane_act[k]) begin
				if (lane_x[k] == outcome) begin
					if (w != W_MAX) row_out[k] = w + WEIGHT_BITS'(1);
				end else begin
					if (w != W_MIN) row_out[k] = w - WEIGHT_BITS'(1);
				end
			end
		end
	end
endmodule
`default_nettype wire
